// File: src/tss_pkg.sv
// tss_pkg: shared types and constants for the triangular solve block
// used by tss_ctrl, tss_datapath and triangular_solve_substitution
`default_nettype none
package tss_pkg;
    localparam logic [1:0] ACT_MATRIX = 2'd0;
    localparam logic [1:0] ACT_VECTOR = 2'd1;
    localparam logic [1:0] ACT_SOLVE  = 2'd2;

    localparam logic [1:0] CFG_DIMENSION = 2'd0;
    localparam logic [1:0] CFG_LOWER     = 2'd1;
    localparam logic [1:0] CFG_TRANS     = 2'd2;
    localparam logic [1:0] CFG_UNIT      = 2'd3;

    // store order, matches the 4-bit row and column fields
    localparam int MAX_ORDER = 16;
    localparam int RESULT_LIMIT = 16;

    // controller to datapath commands
    typedef struct packed {
        logic       load_sum;   // sum <= x[i], clear flag
        logic       mac_rd;     // issue reads of a and x[j]
        logic       mac_mul;    // multiply registered operands
        logic       mac_acc;    // subtract product from sum
        logic       diag_rd;    // issue diagonal read
        logic       div_start;  // start divider
        logic       writeback;  // x[i] <= sum
        logic       out_rd;     // read x[k] for output
        logic [5:0] i;
        logic [5:0] j;
    } tss_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_skip;   // diag was zero or unit
    } tss_stat_t;
endpackage
`default_nettype wire

// File: src/tss_divider.sv
// tss_divider: restoring signed divider, one quotient bit per cycle
// depends on nothing outside this file
`default_nettype none
module tss_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    busy,
    output logic                    done,
    output logic signed [31:0]      quo,
    output logic                    sat
);
    localparam int NW = 32 + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] rem_reg, rem_next, q_reg, q_next;
    logic [31:0]   d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;

    logic [NW-1:0] shifted_rem;
    logic [NW:0]   trial;
    logic [NW-1:0] an;
    logic [31:0]   ad;
    logic [NW:0]   qs;

    always_comb
    begin
        an = num[31] ? NW'(-{{FRACTION_BITS{num[31]}}, num}) : NW'({{FRACTION_BITS{1'b0}}, num});
        an = an << FRACTION_BITS;
        ad = den[31] ? 32'(-den) : den;
    end

    // one restoring step per cycle
    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted_rem = {rem_reg[NW-2:0], q_reg[NW-1]};
        trial = {1'b0, shifted_rem} - {{(NW-31){1'b0}}, d_reg};
        if (start)
        begin
            rem_next = '0;
            q_next = an;
            d_next = ad;
            neg_next = num[31] ^ den[31];
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[NW])
            begin
                rem_next = trial[NW-1:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted_rem;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    // sign fix and clamp
    always_comb
    begin
        qs = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
        sat = 1'b0;
        quo = qs[31:0];
        if (!neg_reg && q_reg > NW'(32'h7FFF_FFFF))
        begin
            sat = 1'b1;
            quo = 32'h7FFF_FFFF;
        end
        else if (neg_reg && q_reg > NW'(33'h0_8000_0000))
        begin
            sat = 1'b1;
            quo = 32'h8000_0000;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// File: src/tss_datapath.sv
// tss_datapath: matrix and vector memories, multiply-subtract, divider
// depends on tss_pkg and tss_divider
`default_nettype none
module tss_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mwr,
    input  wire logic               vwr,
    input  wire logic [3:0]         wrow,
    input  wire logic [3:0]         wcol,
    input  wire logic signed [31:0] wval,
    input  wire logic               transposed,
    input  wire logic               unit_diagonal,
    input  wire tss_pkg::tss_cmd_t  cmd,
    output tss_pkg::tss_stat_t      stat,
    output logic signed [31:0]      out_val,
    output logic                    out_sat
);
    localparam int IW = $clog2(tss_pkg::MAX_ORDER);
    localparam int AW = 2 * IW;

    logic signed [31:0] mat_mem [tss_pkg::MAX_ORDER*tss_pkg::MAX_ORDER];
    logic signed [31:0] vec_mem [tss_pkg::MAX_ORDER];
    logic               sat_mem [tss_pkg::MAX_ORDER];

    logic signed [31:0] a_reg, xv_reg, sum_reg, d_reg;
    logic signed [63:0] prod_reg;
    logic               flag_reg;
    logic [AW-1:0]      maddr;
    logic [IW-1:0]      ci, cj;
    logic signed [31:0] pr;
    logic               pr_sat;
    logic signed [63:0] pround, pshift;
    logic signed [32:0] diff;
    logic               div_busy, div_done, div_sat;
    logic signed [31:0] div_q;
    logic               skip_reg;

    assign ci = cmd.i[IW-1:0];
    assign cj = cmd.j[IW-1:0];

    // matrix address: transposed reads a(j,i)
    always_comb
    begin
        if (cmd.diag_rd)
            maddr = {ci, ci};
        else if (transposed)
            maddr = {cj, ci};
        else
            maddr = {ci, cj};
    end

    // matrix memory, single read port
    always_ff @(posedge clk)
    begin
        if (mwr)
            mat_mem[{wrow[IW-1:0], wcol[IW-1:0]}] <= wval;
        if (cmd.mac_rd || cmd.diag_rd)
            a_reg <= mat_mem[maddr];
    end

    // vector memory, holds b then x
    always_ff @(posedge clk)
    begin
        if (vwr)
            vec_mem[wrow[IW-1:0]] <= wval;
        else if (cmd.writeback)
            vec_mem[ci] <= sum_reg;
        if (cmd.mac_rd)
            xv_reg <= vec_mem[cj];
        else if (cmd.load_sum || cmd.out_rd)
            xv_reg <= vec_mem[ci];
        if (cmd.writeback)
            sat_mem[ci] <= flag_reg;
        if (cmd.out_rd)
            out_sat <= sat_mem[ci];
    end
    assign out_val = xv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mac_mul)
            prod_reg <= a_reg * xv_reg;
    end

    // round half up and clamp product
    always_comb
    begin
        pround = prod_reg + (64'sd1 <<< (FRACTION_BITS - 1));
        pshift = pround >>> FRACTION_BITS;
        pr_sat = 1'b0;
        pr = pshift[31:0];
        if (pshift > 64'sh7FFF_FFFF)
        begin
            pr_sat = 1'b1;
            pr = 32'sh7FFF_FFFF;
        end
        else if (pshift < -64'sh8000_0000)
        begin
            pr_sat = 1'b1;
            pr = -32'sh8000_0000;
        end
        diff = {sum_reg[31], sum_reg} - {pr[31], pr};
    end

    tss_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(sum_reg), .den(a_reg),
        .busy(div_busy), .done(div_done), .quo(div_q), .sat(div_sat)
    );

    // running sum and flag
    always_ff @(posedge clk)
    begin
        if (cmd.load_sum)
        begin
            sum_reg <= vec_mem[ci];
            flag_reg <= 1'b0;
        end
        else if (cmd.mac_acc)
        begin
            if (diff[32] != diff[31])
            begin
                sum_reg <= diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                flag_reg <= 1'b1;
            end
            else
            begin
                sum_reg <= diff[31:0];
                flag_reg <= flag_reg | pr_sat;
            end
        end
        else if (div_done)
        begin
            sum_reg <= div_q;
            flag_reg <= flag_reg | div_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            skip_reg <= unit_diagonal || (a_reg == 32'sd0);
    end

    assign stat.div_busy = (div_busy || div_done) && !skip_reg;
    assign stat.div_skip = unit_diagonal || (a_reg == 32'sd0);
endmodule
`default_nettype wire

// File: src/tss_ctrl.sv
// tss_ctrl: sequencer for substitution and result output
// depends on tss_pkg
`default_nettype none
module tss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start_solve,
    input  wire logic [4:0]        n,
    input  wire logic              forward,
    input  wire tss_pkg::tss_stat_t stat,
    input  wire logic              out_stall,
    output tss_pkg::tss_cmd_t      cmd,
    output logic                   idle,
    output logic                   out_valid,
    output logic [3:0]             out_index,
    output logic                   out_last
);
    localparam logic [3:0] S_IDLE = 4'd0, S_ROW = 4'd1, S_RD = 4'd2, S_MUL = 4'd3,
                           S_ACC = 4'd4, S_DRD = 4'd5, S_DST = 4'd6, S_DWAIT = 4'd7,
                           S_WB = 4'd8, S_ORD = 4'd9, S_OUT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [5:0] k_reg, k_next, j_reg, j_next;
    logic [5:0] i, hi;
    logic [5:0] nn;
    logic       vld_reg, vld_next;

    assign nn = {1'b0, n};
    assign i = forward ? k_reg : 6'(nn - 6'd1 - k_reg);
    assign hi = forward ? i : nn;

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        j_next = j_reg;
        vld_next = vld_reg;
        cmd = '0;
        cmd.i = i;
        cmd.j = j_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_solve && n != 5'd0)
                begin
                    k_next = '0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.load_sum = 1'b1;
                j_next = forward ? 6'd0 : 6'(i + 6'd1);
                state_next = S_RD;
            end
            S_RD:
            begin
                if (j_reg < hi)
                begin
                    cmd.mac_rd = 1'b1;
                    state_next = S_MUL;
                end
                else
                    state_next = S_DRD;
            end
            S_MUL:
            begin
                cmd.mac_mul = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.mac_acc = 1'b1;
                j_next = j_reg + 6'd1;
                state_next = S_RD;
            end
            S_DRD:
            begin
                cmd.diag_rd = 1'b1;
                state_next = S_DST;
            end
            S_DST:
            begin
                if (stat.div_skip)
                    state_next = S_WB;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_WB;
            end
            S_WB:
            begin
                cmd.writeback = 1'b1;
                if (k_reg == nn - 6'd1)
                begin
                    k_next = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    k_next = k_reg + 6'd1;
                    state_next = S_ROW;
                end
            end
            S_ORD:
            begin
                cmd.i = k_reg;
                cmd.out_rd = 1'b1;
                vld_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.i = k_reg;
                if (!out_stall)
                begin
                    vld_next = 1'b0;
                    if (k_reg == nn - 6'd1)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next = k_reg + 6'd1;
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= '0;
            j_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            j_reg <= j_next;
            vld_reg <= vld_next;
        end
    end

    assign idle = (state_reg == S_IDLE);
    assign out_valid = vld_reg;
    assign out_index = k_reg[3:0];
    assign out_last = (k_reg == nn - 6'd1);
endmodule
`default_nettype wire

// File: src/triangular_solve_substitution.sv
// triangular_solve_substitution: top level of the fixed-point triangular solver
// depends on tss_pkg, tss_ctrl, tss_datapath, tss_divider
//
// usage: load matrix entries (action 0) and right-hand-side entries (action 1)
// one beat per cycle; a solve beat (action 2) runs substitution over the
// loaded triangle and emits n result beats in index order, last marked.
// in_stall is high while a solve runs, so nothing is taken meanwhile.
// each element of a solve loads its sum, then runs a read, multiply and
// subtract step per term, then reads the diagonal and, when the diagonal
// is stored and nonzero, waits for the divider before writeback; solve time
// is set by the single matrix read port and the bit-serial divider. each
// result beat passes through a read state and an output state.
// the solution overwrites the vector memory.
// reset clears control and sets dimension 16, all mode bits 0; the
// memories are not cleared. when out_stall is high the current result beat
// holds until taken.
`default_nettype none
module triangular_solve_substitution #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [4:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [3:0]         row,
    input  wire logic [3:0]         col,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              index,
    output logic signed [31:0]      solution,
    output logic                    saturated,
    output logic                    last
);
    logic [4:0] dim_reg;
    logic       lower_reg, trans_reg, unit_reg;
    logic       idle, acc, inrange_r, inrange_c;
    logic [4:0] n;
    tss_pkg::tss_cmd_t  cmd;
    tss_pkg::tss_stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 5'd16;
            lower_reg <= 1'b0;
            trans_reg <= 1'b0;
            unit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tss_pkg::CFG_DIMENSION: dim_reg <= cfg_data;
                tss_pkg::CFG_LOWER:     lower_reg <= cfg_data[0];
                tss_pkg::CFG_TRANS:     trans_reg <= cfg_data[0];
                tss_pkg::CFG_UNIT:      unit_reg <= cfg_data[0];
            endcase
        end
    end

    // clamp order to the smaller of store size and result limit
    always_comb
    begin
        n = dim_reg;
        if (32'(dim_reg) > tss_pkg::MAX_ORDER)
            n = 5'(tss_pkg::MAX_ORDER);
        if (32'(n) > tss_pkg::RESULT_LIMIT)
            n = 5'(tss_pkg::RESULT_LIMIT);
    end

    assign in_stall = !idle;
    assign acc = in_valid && idle;
    assign inrange_r = (32'(row) < tss_pkg::MAX_ORDER);
    assign inrange_c = (32'(col) < tss_pkg::MAX_ORDER);

    tss_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .start_solve(acc && action == tss_pkg::ACT_SOLVE),
        .n(n), .forward(lower_reg != trans_reg), .stat(stat),
        .out_stall(out_stall), .cmd(cmd), .idle(idle),
        .out_valid(out_valid), .out_index(index), .out_last(last)
    );

    tss_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .mwr(acc && action == tss_pkg::ACT_MATRIX && inrange_r && inrange_c),
        .vwr(acc && action == tss_pkg::ACT_VECTOR && inrange_r),
        .wrow(row), .wcol(col), .wval(value),
        .transposed(trans_reg), .unit_diagonal(unit_reg),
        .cmd(cmd), .stat(stat), .out_val(solution), .out_sat(saturated)
    );

    // results only leave while a solve is running
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result beat while idle");
    // a stalled result beat holds its index
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(index))
        else $error("stalled result dropped");
    // an accepted solve beat with nonzero dimension raises in_stall
    a_solve: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == tss_pkg::ACT_SOLVE && dim_reg != 5'd0
        |=> in_stall)
        else $error("solve did not start");
endmodule
`default_nettype wire

// File: tb/tss_checker.sv
// tss_checker: watches the channels of triangular_solve_substitution, predicts
// each solve and compares every result beat; depends on tss_pkg
`timescale 1ns / 100ps
module tss_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [4:0]         cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [3:0]         row,
    input  wire logic [3:0]         col,
    input  wire logic signed [31:0] value,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [3:0]         index,
    input  wire logic signed [31:0] solution,
    input  wire logic               saturated,
    input  wire logic               last,
    output int                      errors,
    output int                      pending
);
    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] x;
        logic               sat;
        logic               lst;
    } solution_beat_t;

    solution_beat_t     solution_q[$];
    logic signed [31:0] mat_copy[256];
    logic signed [31:0] vec_copy[16];
    logic [4:0]         order_reg;
    logic               lower_reg;
    logic               trans_reg;
    logic               unit_reg;

    initial
    begin
        errors = 0;
        pending = 0;
    end

    // clamp to 32 bits and note saturation
    function automatic logic signed [31:0] clamp_q(input longint v, inout logic f);
        if (v > 64'sd2147483647)
        begin
            f = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            f = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // rounded q16.16 product, half up
    function automatic logic signed [31:0] fx_product(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      inout logic f);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clamp_q(p >>> 16, f);
    endfunction

    // q16.16 quotient, truncated toward zero
    function automatic logic signed [31:0] fx_quotient(input logic signed [31:0] num,
                                                       input logic signed [31:0] den,
                                                       inout logic f);
        longint scaled;
        scaled = longint'(num) * 64'sd65536;
        return clamp_q(scaled / longint'(den), f);
    endfunction

    // substitution over the mirrored stores, expected beats queued in order
    task automatic predict_solution();
        int                 n;
        int                 i;
        int                 lo;
        int                 hi;
        logic               fwd;
        logic               f;
        logic signed [31:0] sum;
        logic signed [31:0] a;
        logic signed [31:0] p;
        logic signed [31:0] d;
        logic signed [31:0] x[16];
        logic               s[16];
        solution_beat_t     b;
        n = (order_reg > 16) ? 16 : order_reg;
        fwd = lower_reg ^ trans_reg;
        for (int k = 0; k < n; k++)
        begin
            x[k] = vec_copy[k];
            s[k] = 1'b0;
        end
        for (int k = 0; k < n; k++)
        begin
            i = fwd ? k : n - 1 - k;
            f = 1'b0;
            sum = x[i];
            lo = fwd ? 0 : i + 1;
            hi = fwd ? i : n;
            for (int j = lo; j < hi; j++)
            begin
                a = trans_reg ? mat_copy[j * 16 + i] : mat_copy[i * 16 + j];
                p = fx_product(a, x[j], f);
                sum = clamp_q(longint'(sum) - longint'(p), f);
            end
            if (!unit_reg)
            begin
                d = mat_copy[i * 16 + i];
                // zero diagonal passes the sum through
                if (d != 0)
                    sum = fx_quotient(sum, d, f);
            end
            x[i] = sum;
            s[i] = f;
        end
        for (int k = 0; k < n; k++)
        begin
            vec_copy[k] = x[k];
            b.idx = k[3:0];
            b.x = x[k];
            b.sat = s[k];
            b.lst = (k == n - 1);
            solution_q.push_back(b);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // configuration mirror
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 5'd16;
            lower_reg <= 1'b0;
            trans_reg <= 1'b0;
            unit_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tss_pkg::CFG_DIMENSION: order_reg <= cfg_data;
                tss_pkg::CFG_LOWER:     lower_reg <= cfg_data[0];
                tss_pkg::CFG_TRANS:     trans_reg <= cfg_data[0];
                tss_pkg::CFG_UNIT:      unit_reg  <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // result beats compared first, then the input beat is applied
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (solution_q.size() == 0)
                begin
                    report("unexpected beat, index", 32'(index), 32'd0);
                end
                else
                begin
                    solution_beat_t b;
                    b = solution_q.pop_front();
                    if (index !== b.idx)
                        report("index", 32'(index), 32'(b.idx));
                    if (solution !== b.x)
                        report("solution", solution, b.x);
                    if (saturated !== b.sat)
                        report("saturated", 32'(saturated), 32'(b.sat));
                    if (last !== b.lst)
                        report("last", 32'(last), 32'(b.lst));
                end
            end
            if (in_valid && !in_stall)
            begin
                case (action)
                    tss_pkg::ACT_MATRIX: mat_copy[{row, col}] = value;
                    tss_pkg::ACT_VECTOR: vec_copy[row] = value;
                    tss_pkg::ACT_SOLVE:  predict_solution();
                    default:             ;
                endcase
            end
        end
        pending <= solution_q.size();
    end
endmodule

// File: tb/triangular_solve_substitution_tb.sv
// triangular_solve_substitution_tb: stimulus, receiver stalls and verdict
// depends on tss_pkg, tss_checker and the triangular_solve_substitution rtl
`timescale 1ns / 100ps
module triangular_solve_substitution_tb;
    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int         CYCLE_LIMIT = 800000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [4:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               saturated;
    logic               last;
    int                 errors;
    int                 pending;

    logic               mat_written[256];
    logic               vec_written[16];
    logic [4:0]         cur_order;
    logic               cur_lower;
    logic               cur_unit;
    int                 burst_left;
    int                 item_count;
    logic               hold_off = 1'b0;
    int                 cycles = 0;

    triangular_solve_substitution uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .row(row), .col(col), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .index(index), .solution(solution), .saturated(saturated), .last(last)
    );

    tss_checker check (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .row(row), .col(col), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .index(index), .solution(solution), .saturated(saturated), .last(last),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[triangular_solve_substitution] ERROR");
            $finish;
        end
    end

    // receiver: stall pattern switches at random among no, light and heavy stalling
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
            0:       out_stall <= hold_off;
            1:       out_stall <= hold_off || ($urandom_range(0, 9) < 3);
            default: out_stall <= hold_off || ($urandom_range(0, 9) < 8);
        endcase
    end

    // long hold-off once a solve is under way and the sender offers more beats
    initial
    begin
        @(posedge clk);
        while (!(pending > 0 && in_valid))
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (500) @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return 32'sd0;
            3:       return $urandom;
            default: return $signed($urandom_range(0, 262143)) - 32'sd131072;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_diag();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       return 32'sd0;
            1:       return pick_value();
            default:
            begin
                v = $urandom_range(32768, 196608);
                return $urandom_range(0, 1) ? v : -v;
            end
        endcase
    endfunction

    // one input beat; valid stays high across back-to-back beats
    task automatic send(input logic [1:0] a, input logic [3:0] r, input logic [3:0] c,
                        input logic signed [31:0] v);
        in_valid <= 1'b1;
        action <= a;
        row <= r;
        col <= c;
        value <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (a == tss_pkg::ACT_MATRIX)
            mat_written[{r, c}] = 1'b1;
        if (a == tss_pkg::ACT_VECTOR)
            vec_written[r] = 1'b1;
        if (a != ACT_IGNORED)
            item_count++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // drain results, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(input logic [4:0] n, input logic lo, input logic tr,
                              input logic un);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= tss_pkg::CFG_DIMENSION;
        cfg_data <= n;
        @(posedge clk);
        cfg_index <= tss_pkg::CFG_LOWER;
        cfg_data <= {4'd0, lo};
        @(posedge clk);
        cfg_index <= tss_pkg::CFG_TRANS;
        cfg_data <= {4'd0, tr};
        @(posedge clk);
        cfg_index <= tss_pkg::CFG_UNIT;
        cfg_data <= {4'd0, un};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_order = n;
        cur_lower = lo;
        cur_unit = un;
    endtask

    // load whatever the solve will read that was never written, then solve
    task automatic run_solve();
        int n;
        n = (cur_order > 16) ? 16 : cur_order;
        for (int r = 0; r < n; r++)
        begin
            if (!vec_written[r])
                send(tss_pkg::ACT_VECTOR, 4'(r), 4'($urandom), pick_value());
            for (int c = 0; c < n; c++)
            begin
                if ((cur_lower ? r > c : r < c) && !mat_written[r * 16 + c])
                    send(tss_pkg::ACT_MATRIX, 4'(r), 4'(c), pick_value());
                if (r == c && !cur_unit && !mat_written[r * 16 + c])
                    send(tss_pkg::ACT_MATRIX, 4'(r), 4'(c), pick_diag());
            end
        end
        send(tss_pkg::ACT_SOLVE, 4'($urandom), 4'($urandom), $urandom);
    endtask

    initial
    begin
        logic [4:0] n;
        int         len;
        int         r;
        int         c;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tss_pkg::CFG_DIMENSION;
        cfg_data = 5'd0;
        in_valid = 1'b0;
        action = tss_pkg::ACT_MATRIX;
        row = 4'd0;
        col = 4'd0;
        value = 32'sd0;
        burst_left = 4;
        item_count = 0;
        foreach (mat_written[k])
            mat_written[k] = 1'b0;
        foreach (vec_written[k])
            vec_written[k] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero diagonal, ignored action
        set_config(5'd2, 1'b1, 1'b0, 1'b0);
        send(tss_pkg::ACT_MATRIX, 4'd0, 4'd0, 32'sd0);
        send(tss_pkg::ACT_MATRIX, 4'd1, 4'd0, 32'sh7fffffff);
        send(tss_pkg::ACT_MATRIX, 4'd1, 4'd1, 32'sh80000000);
        send(tss_pkg::ACT_VECTOR, 4'd0, 4'd15, 32'sh7fffffff);
        send(tss_pkg::ACT_VECTOR, 4'd1, 4'd0, 32'sh80000000);
        send(ACT_IGNORED, 4'd15, 4'd15, 32'sh7fffffff);
        run_solve();
        send(tss_pkg::ACT_MATRIX, 4'd0, 4'd0, 32'sd1);
        send(tss_pkg::ACT_MATRIX, 4'd1, 4'd1, 32'sh80000000);
        send(tss_pkg::ACT_VECTOR, 4'd0, 4'd0, 32'sh80000000);
        run_solve();
        // dimension zero emits nothing
        set_config(5'd0, 1'b0, 1'b0, 1'b0);
        run_solve();
        // oversized dimension clamps to full order
        set_config(5'd31, 1'b0, 1'b1, 1'b1);
        run_solve();
        // full order again on the loaded upper triangle, stored diagonal
        set_config(5'd16, 1'b0, 1'b1, 1'b0);
        run_solve();
        set_config(5'd1, 1'b0, 1'b0, 1'b0);
        send(tss_pkg::ACT_MATRIX, 4'd0, 4'd0, 32'sh80000000);
        send(tss_pkg::ACT_VECTOR, 4'd0, 4'd0, 32'sh7fffffff);
        run_solve();

        // random phases: new settings, then loads and solves
        while (item_count < 210)
        begin
            case ($urandom_range(0, 11))
                0:       n = 5'd0;
                1:       n = 5'($urandom_range(17, 31));
                2, 3:    n = 5'd16;
                default: n = 5'($urandom_range(1, 6));
            endcase
            // full order stays on the upper triangle loaded above
            set_config(n, (n < 5'd16) && ($urandom_range(0, 1) != 0),
                       1'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 3))
            begin
                len = $urandom_range(2, 14);
                for (int k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, (n == 0 || n > 16) ? 15 : n - 1);
                    c = $urandom_range(0, (n == 0 || n > 16) ? 15 : n - 1);
                    case ($urandom_range(0, 9))
                        0:       send(ACT_IGNORED, 4'($urandom), 4'($urandom), $urandom);
                        1:       send(tss_pkg::ACT_MATRIX, 4'($urandom), 4'($urandom),
                                      pick_value());
                        2, 3:    send(tss_pkg::ACT_VECTOR, 4'(r), 4'($urandom), pick_value());
                        4:       send(tss_pkg::ACT_MATRIX, 4'(r), 4'(r), pick_diag());
                        default: send(tss_pkg::ACT_MATRIX, 4'(r), 4'(c), pick_value());
                    endcase
                end
                run_solve();
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[triangular_solve_substitution] OK");
        else
            $display("[triangular_solve_substitution] ERROR");
        $finish;
    end
endmodule
